// ===== rtl/core/bsd_pkg.sv =====
// shared types and constants of the bmp stream decoder
package bsd_pkg;

	localparam int MAX_DIM    = 2048;
	localparam int FILE_LIMIT = 262144;

	localparam int DimW   = $clog2(MAX_DIM + 1);
	localparam int ColW   = $clog2(MAX_DIM);
	localparam int CountW = $clog2(FILE_LIMIT + 1);
	localparam int PosW   = 6;

	localparam logic [15:0] BmSig = 16'h4D42;
	localparam int HdrLen    = 34;
	localparam int OffSig    = 0;
	localparam int OffPix    = 10;
	localparam int OffWidth  = 18;
	localparam int OffHeight = 22;
	localparam int OffDepth  = 28;
	localparam int OffComp   = 30;
	localparam int Depth24   = 24;
	localparam int Depth32   = 32;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DRAIN
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK,
		ST_SHORT,
		ST_SIG,
		ST_DEPTH,
		ST_COMP,
		ST_WIDTH,
		ST_HEIGHT,
		ST_OFFSET,
		ST_TRUNC
	} stat_t;

	typedef enum logic [1:0] {
		KIND_PIXEL,
		KIND_VERDICT,
		KIND_FINISH
	} kind_t;

	typedef struct packed {
		stat_t             verdict;
		logic [DimW-1:0]   width;
		logic [DimW-1:0]   height;
		logic              flip_rows;
		logic              depth32;
		logic [31:0]       offset;
	} hdr_t;

	typedef struct packed {
		kind_t             kind;
		stat_t             status;
		logic [23:0]       rgb;
		logic [ColW-1:0]   dest_row;
		logic [ColW-1:0]   dest_col;
		logic [DimW-1:0]   image_width;
		logic [DimW-1:0]   image_height;
		logic              flip_rows;
		logic [DimW-1:0]   rows_done;
		logic              last_pixel;
		logic              done_res;
	} res_t;

endpackage

// ===== rtl/core/bmp_stream_decoder.sv =====
// top level of the bmp stream decoder: byte sequencing, pixel packing, result register
// an accepted byte passes the input register, then the result register, before its result shows
// throughput: one byte per cycle unless the result stalls, set by the single update of the byte counters per cycle
// a stalled result holds the pipeline; the input register takes a byte whenever it is empty or can advance
// reset: arst_n clears all control state and the header fields; the decoder waits for byte 0
// the byte marked last also returns every counter and field to the reset state
module bmp_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // status, rgb, dest_row, dest_col, image_width,
	                               // image_height, flip_rows, rows_done, last_pixel
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // done_res
);

	localparam int DimW   = bsd_pkg::DimW;
	localparam int ColW   = bsd_pkg::ColW;
	localparam int CountW = bsd_pkg::CountW;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 adv;

	bsd_pkg::phase_t      phase_q, phase_u;
	logic [CountW-1:0]    pos_q, pos_u;
	logic [DimW-1:0]      row_q, row_u;
	logic [ColW-1:0]      col_q, col_u;
	logic [1:0]           bip_q, bip_u;
	logic [1:0]           pad_q, pad_u;
	logic [15:0]          partial_q, partial_u;
	bsd_pkg::stat_t       verdict_q, verdict_u;

	bsd_pkg::hdr_t        hdr;
	bsd_pkg::res_t        res, res_q;
	logic                 res_valid_q;
	logic                 have;

	logic                 in_range;
	logic                 pix_go;
	logic                 pix_emit;
	logic                 ver_emit;
	logic                 px_end;
	logic [DimW-1:0]      col_inc;
	logic [DimW-1:0]      row_inc;
	logic [DimW-1:0]      dr_full;

	assign adv      = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	bsd_header u_header (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (adv && in_range && phase_q == bsd_pkg::PH_HEADER),
		.clr       (adv && last_s1),
		.pos       (pos_q[bsd_pkg::PosW-1:0]),
		.data_byte (byte_s1),
		.hdr       (hdr)
	);

	assign in_range = pos_q < CountW'(bsd_pkg::FILE_LIMIT);
	assign pix_go   = (phase_q == bsd_pkg::PH_PIXELS) ||
	                  ({{(32-CountW){1'b0}}, pos_q} == hdr.offset);
	assign px_end   = hdr.depth32 ? (bip_q == 2'd3) : (bip_q == 2'd2);
	assign col_inc  = {1'b0, col_q} + DimW'(1);
	assign row_inc  = row_q + DimW'(1);
	assign dr_full  = hdr.flip_rows ? (hdr.height - DimW'(1) - row_q) : row_q;

	// next state, before the close on the last byte
	always_comb begin
		phase_u   = phase_q;
		pos_u     = pos_q;
		row_u     = row_q;
		col_u     = col_q;
		bip_u     = bip_q;
		pad_u     = pad_q;
		partial_u = partial_q;
		verdict_u = verdict_q;
		if (in_range) begin
			pos_u = pos_q + CountW'(1);
			unique case (phase_q) inside
				bsd_pkg::PH_HEADER: begin
					if (pos_q == CountW'(bsd_pkg::HdrLen - 1)) begin
						verdict_u = hdr.verdict;
						phase_u   = (hdr.verdict == bsd_pkg::ST_OK) ? bsd_pkg::PH_SKIP
						                                             : bsd_pkg::PH_DRAIN;
					end
				end
				bsd_pkg::PH_SKIP, bsd_pkg::PH_PIXELS: begin
					if (pix_go) begin
						phase_u = bsd_pkg::PH_PIXELS;
						if (pad_q != 2'd0) begin
							pad_u = pad_q - 2'd1;
						end else begin
							if (bip_q == 2'd0) partial_u = {8'd0, byte_s1};
							else if (bip_q == 2'd1) partial_u[15:8] = byte_s1;
							if (px_end) begin
								bip_u = 2'd0;
								if (col_inc >= hdr.width) begin
									col_u = '0;
									row_u = row_inc;
									if (row_inc >= hdr.height) phase_u = bsd_pkg::PH_DRAIN;
									else if (!hdr.depth32) pad_u = hdr.width[1:0];
								end else begin
									col_u = col_inc[ColW-1:0];
								end
							end else begin
								bip_u = bip_q + 2'd1;
							end
						end
					end
				end
				bsd_pkg::PH_DRAIN: begin
				end
				default: begin
				end
			endcase
		end
	end

	// result of the current item
	always_comb begin
		res      = '0;
		ver_emit = in_range && phase_q == bsd_pkg::PH_HEADER &&
		           pos_q == CountW'(bsd_pkg::HdrLen - 1);
		pix_emit = in_range && (phase_q == bsd_pkg::PH_SKIP || phase_q == bsd_pkg::PH_PIXELS) &&
		           pix_go && pad_q == 2'd0 && bip_q == 2'd2;
		if (ver_emit) begin
			res.kind   = bsd_pkg::KIND_VERDICT;
			res.status = hdr.verdict;
			if (hdr.verdict == bsd_pkg::ST_OK) begin
				res.image_width  = hdr.width;
				res.image_height = hdr.height;
				res.flip_rows    = hdr.flip_rows;
			end
		end else if (pix_emit) begin
			res.kind       = bsd_pkg::KIND_PIXEL;
			res.rgb        = {byte_s1, partial_q};
			res.dest_row   = dr_full[ColW-1:0];
			res.dest_col   = col_q;
			res.last_pixel = (col_inc == hdr.width) && (row_inc == hdr.height);
		end
		if (last_s1) begin
			if (!(ver_emit || pix_emit)) res.kind = bsd_pkg::KIND_FINISH;
			unique case (phase_u)
				bsd_pkg::PH_HEADER: res.status = bsd_pkg::ST_SHORT;
				bsd_pkg::PH_SKIP:   res.status = bsd_pkg::ST_OFFSET;
				bsd_pkg::PH_PIXELS: res.status = bsd_pkg::ST_TRUNC;
				default:            res.status = verdict_u;
			endcase
			res.rows_done = row_u;
			res.done_res  = 1'b1;
		end
		have = ver_emit || pix_emit || last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bsd_pkg::PH_HEADER;
			pos_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			bip_q     <= '0;
			pad_q     <= '0;
			partial_q <= '0;
			verdict_q <= bsd_pkg::ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				phase_q   <= bsd_pkg::PH_HEADER;
				pos_q     <= '0;
				row_q     <= '0;
				col_q     <= '0;
				bip_q     <= '0;
				pad_q     <= '0;
				partial_q <= '0;
				verdict_q <= bsd_pkg::ST_OK;
			end else begin
				phase_q   <= phase_u;
				pos_q     <= pos_u;
				row_q     <= row_u;
				col_q     <= col_u;
				bip_q     <= bip_u;
				pad_q     <= pad_u;
				partial_q <= partial_u;
				verdict_q <= verdict_u;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && have) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have) res_q <= res;
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.done_res;
	assign m_tdata  = {res_q.last_pixel, res_q.rows_done, res_q.flip_rows, res_q.image_height,
	                   res_q.image_width, res_q.dest_col, res_q.dest_row, res_q.rgb,
	                   res_q.status};

	// closing byte brings the sequencer back to the start of a file
	a_close_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == bsd_pkg::PH_HEADER && pos_q == '0 && row_q == '0)
		else $error("decoder state not cleared after closing byte");

	// a header verdict only comes on the last header byte
	a_verdict_pos: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.kind == bsd_pkg::KIND_VERDICT && !last_s1 |->
		pos_q == CountW'(bsd_pkg::HdrLen - 1))
		else $error("verdict outside header end");

	// while pixels are taken the row count stays below the image height
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bsd_pkg::PH_PIXELS |-> row_q < hdr.height)
		else $error("row count past image height in pixel phase");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !m_tready |=> $stable(res_q))
		else $error("waiting result overwritten");

endmodule

// ===== rtl/core/bsd_header.sv =====
// header field capture and header check of the bmp stream decoder
module bsd_header (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic                     clr,
	input  logic [bsd_pkg::PosW-1:0] pos,
	input  logic [7:0]               data_byte,
	output bsd_pkg::hdr_t            hdr
);

	logic [15:0]               sig_q;
	logic [31:0]               offset_q;
	logic [31:0]               width_q;
	logic [31:0]               height_q;
	logic [15:0]               depth_q;
	logic [31:0]               compress_q;
	logic [bsd_pkg::DimW-1:0]  hmag_q;
	logic                      h_bad_q;
	logic                      flip_rows_q;
	logic [31:0]               mag;
	logic [31:0]               comp_full;
	bsd_pkg::stat_t            verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q      <= '0;
			offset_q   <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			compress_q <= '0;
		end else if (clr) begin
			sig_q      <= '0;
			offset_q   <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			compress_q <= '0;
		end else if (we) begin
			for (int i = 0; i < 2; i++) begin
				if (pos == bsd_pkg::PosW'(bsd_pkg::OffSig + i)) sig_q[8*i +: 8] <= data_byte;
				if (pos == bsd_pkg::PosW'(bsd_pkg::OffDepth + i)) depth_q[8*i +: 8] <= data_byte;
			end
			for (int i = 0; i < 4; i++) begin
				if (pos == bsd_pkg::PosW'(bsd_pkg::OffPix + i)) offset_q[8*i +: 8] <= data_byte;
				if (pos == bsd_pkg::PosW'(bsd_pkg::OffWidth + i)) width_q[8*i +: 8] <= data_byte;
				if (pos == bsd_pkg::PosW'(bsd_pkg::OffHeight + i))
					height_q[8*i +: 8] <= data_byte;
				if (pos == bsd_pkg::PosW'(bsd_pkg::OffComp + i))
					compress_q[8*i +: 8] <= data_byte;
			end
		end
	end

	// height is complete long before the check, so its magnitude is taken from a register
	assign mag = height_q[31] ? (32'd0 - height_q) : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmag_q      <= '0;
			h_bad_q     <= 1'b1;
			flip_rows_q <= 1'b0;
		end else begin
			hmag_q      <= mag[bsd_pkg::DimW-1:0];
			h_bad_q     <= (mag == 32'd0) || (mag > 32'(bsd_pkg::MAX_DIM));
			flip_rows_q <= (height_q != 32'd0) && !height_q[31];
		end
	end

	// the check runs on the last header byte, which is the top compression byte
	assign comp_full = {data_byte, compress_q[23:0]};

	always_comb begin
		if (sig_q != bsd_pkg::BmSig) begin
			verdict = bsd_pkg::ST_SIG;
		end else if (depth_q != 16'(bsd_pkg::Depth24) && depth_q != 16'(bsd_pkg::Depth32)) begin
			verdict = bsd_pkg::ST_DEPTH;
		end else if (comp_full != 32'd0) begin
			verdict = bsd_pkg::ST_COMP;
		end else if (width_q == 32'd0 || width_q > 32'(bsd_pkg::MAX_DIM)) begin
			verdict = bsd_pkg::ST_WIDTH;
		end else if (h_bad_q) begin
			verdict = bsd_pkg::ST_HEIGHT;
		end else if (offset_q < 32'(bsd_pkg::HdrLen)) begin
			verdict = bsd_pkg::ST_OFFSET;
		end else begin
			verdict = bsd_pkg::ST_OK;
		end
	end

	assign hdr.verdict   = verdict;
	assign hdr.width     = width_q[bsd_pkg::DimW-1:0];
	assign hdr.height    = hmag_q;
	assign hdr.flip_rows = flip_rows_q;
	assign hdr.depth32   = (depth_q == 16'(bsd_pkg::Depth32));
	assign hdr.offset    = offset_q;

endmodule

// ===== verif/bsd_checker.sv =====
// result checker of the bmp stream decoder: watches both channels, predicts each item, compares
module bsd_checker import bsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // is_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // status, rgb, dest_row, dest_col, image_width,
	                               // image_height, flip_rows, rows_done, last_pixel
	input  logic [1:0]  m_tuser,   // kind
	input  logic        m_tlast,   // done_res
	output int          errors,
	output int          pending
);

	// decoder state as the predictor sees it
	logic [CountW-1:0] file_pos;
	phase_t            stage;
	logic [15:0]       sig_w;
	logic [31:0]       pix_off;
	logic [31:0]       img_w;
	logic [31:0]       img_h_raw;
	logic [15:0]       bpp;
	logic [31:0]       comp_w;
	logic [DimW-1:0]   rows_in;
	logic [DimW-1:0]   col_in;
	logic [1:0]        byte_in_px;
	logic [1:0]        pad_skip;
	logic [15:0]       px_lo;

	res_t expected_q[$];
	int   err_count = 0;

	assign errors  = err_count;
	assign pending = expected_q.size();

	function automatic logic [31:0] height_abs();
		return img_h_raw[31] ? 32'd0 - img_h_raw : img_h_raw;
	endfunction

	function automatic logic rows_reversed();
		return img_h_raw != 32'd0 && !img_h_raw[31];
	endfunction

	function automatic stat_t header_status();
		logic [31:0] hm;
		hm = height_abs();
		if (sig_w != BmSig) return ST_SIG;
		if (bpp != Depth24 && bpp != Depth32) return ST_DEPTH;
		if (comp_w != 32'd0) return ST_COMP;
		if (img_w == 32'd0 || img_w > MAX_DIM) return ST_WIDTH;
		if (hm == 32'd0 || hm > MAX_DIM) return ST_HEIGHT;
		if (pix_off < HdrLen) return ST_OFFSET;
		return ST_OK;
	endfunction

	function automatic stat_t close_status();
		stat_t v;
		case (stage)
			PH_HEADER: return ST_SHORT;
			PH_SKIP:   return ST_OFFSET;
			PH_PIXELS: return ST_TRUNC;
			default: begin
				v = header_status();
				if (v != ST_OK) return v;
				return (rows_in >= height_abs()) ? ST_OK : ST_TRUNC;
			end
		endcase
	endfunction

	function automatic string show(res_t x);
		return $sformatf({"kind %0d st %0d rgb %06h row %0d col %0d w %0d h %0d",
			" flip %0d rows %0d lp %0d dn %0d"},
			x.kind, x.status, x.rgb, x.dest_row, x.dest_col, x.image_width, x.image_height,
			x.flip_rows, x.rows_done, x.last_pixel, x.done_res);
	endfunction

	task automatic clear_state();
		file_pos   = '0;
		stage      = PH_HEADER;
		sig_w      = '0;
		pix_off    = '0;
		img_w      = '0;
		img_h_raw  = '0;
		bpp        = '0;
		comp_w     = '0;
		rows_in    = '0;
		col_in     = '0;
		byte_in_px = '0;
		pad_skip   = '0;
		px_lo      = '0;
	endtask

	task automatic pack_pixel_byte(input logic [7:0] b, inout res_t r, output bit made);
		int          nb;
		logic [31:0] hm;
		logic [31:0] dr;
		nb   = (bpp == Depth32) ? 4 : 3;
		hm   = height_abs();
		made = 1'b0;
		if (pad_skip > 0) begin
			pad_skip = pad_skip - 1'b1;
		end else begin
			if (byte_in_px == 2'd0) begin
				px_lo = {8'd0, b};
			end else if (byte_in_px == 2'd1) begin
				px_lo[15:8] = b;
			end else if (byte_in_px == 2'd2) begin
				dr = rows_reversed() ? hm - 32'd1 - rows_in : 32'(rows_in);
				r.kind       = KIND_PIXEL;
				r.rgb        = {b, px_lo};
				r.dest_row   = dr[ColW-1:0];
				r.dest_col   = col_in[ColW-1:0];
				r.last_pixel = (col_in + 32'd1 == img_w) && (rows_in + 32'd1 == hm);
				made = 1'b1;
			end
			if (byte_in_px + 1 >= nb) begin
				byte_in_px = '0;
				col_in = col_in + 1'b1;
				if (col_in >= img_w) begin
					col_in  = '0;
					rows_in = rows_in + 1'b1;
					if (rows_in >= hm) stage = PH_DRAIN;
					else if (nb == 3) pad_skip = img_w[1:0];
				end
			end else begin
				byte_in_px = byte_in_px + 1'b1;
			end
		end
	endtask

	task automatic predict_item(input logic [7:0] b, input logic last);
		res_t        r;
		bit          got;
		logic [31:0] pos;
		logic [31:0] hm;
		stat_t       v;
		r   = '0;
		got = 1'b0;
		pos = 32'(file_pos);
		if (pos < FILE_LIMIT) begin
			file_pos = file_pos + 1'b1;
			if (stage == PH_HEADER) begin
				if (pos < 2) sig_w[pos*8 +: 8] = b;
				else if (pos >= OffPix && pos < OffPix + 4) pix_off[(pos-OffPix)*8 +: 8] = b;
				else if (pos >= OffWidth && pos < OffWidth + 4) img_w[(pos-OffWidth)*8 +: 8] = b;
				else if (pos >= OffHeight && pos < OffHeight + 4)
					img_h_raw[(pos-OffHeight)*8 +: 8] = b;
				else if (pos >= OffDepth && pos < OffDepth + 2) bpp[(pos-OffDepth)*8 +: 8] = b;
				else if (pos >= OffComp && pos < OffComp + 4) comp_w[(pos-OffComp)*8 +: 8] = b;
				if (pos + 1 == HdrLen) begin
					v  = header_status();
					hm = height_abs();
					r.kind   = KIND_VERDICT;
					r.status = v;
					if (v == ST_OK) begin
						r.image_width  = img_w[DimW-1:0];
						r.image_height = hm[DimW-1:0];
						r.flip_rows    = rows_reversed();
						stage = PH_SKIP;
					end else begin
						stage = PH_DRAIN;
					end
					got = 1'b1;
				end
			end else if (stage == PH_SKIP || stage == PH_PIXELS) begin
				if (stage == PH_SKIP && pos == pix_off) stage = PH_PIXELS;
				if (stage == PH_PIXELS) pack_pixel_byte(b, r, got);
			end
		end
		if (last) begin
			if (!got) begin
				r = '0;
				r.kind = KIND_FINISH;
				got = 1'b1;
			end
			r.status    = close_status();
			r.rows_done = rows_in;
			r.done_res  = 1'b1;
			clear_state();
		end
		if (got) expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t seen;
		res_t want;
		if (!arst_n) begin
			clear_state();
			expected_q.delete();
		end else begin
			if (s_tvalid && s_tready) predict_item(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				seen.kind         = kind_t'(m_tuser);
				seen.status       = stat_t'(m_tdata[3:0]);
				seen.rgb          = m_tdata[27:4];
				seen.dest_row     = m_tdata[38:28];
				seen.dest_col     = m_tdata[49:39];
				seen.image_width  = m_tdata[61:50];
				seen.image_height = m_tdata[73:62];
				seen.flip_rows    = m_tdata[74];
				seen.rows_done    = m_tdata[86:75];
				seen.last_pixel   = m_tdata[87];
				seen.done_res     = m_tlast;
				if (expected_q.size() == 0) begin
					err_count++;
					if (err_count <= 10) $display("unexpected result: %s", show(seen));
				end else begin
					want = expected_q.pop_front();
					if (seen.kind !== want.kind || seen.status !== want.status ||
					    seen.rgb !== want.rgb || seen.dest_row !== want.dest_row ||
					    seen.dest_col !== want.dest_col ||
					    seen.image_width !== want.image_width ||
					    seen.image_height !== want.image_height ||
					    seen.flip_rows !== want.flip_rows ||
					    seen.rows_done !== want.rows_done ||
					    seen.last_pixel !== want.last_pixel ||
					    seen.done_res !== want.done_res) begin
						err_count++;
						if (err_count <= 10) begin
							$display("mismatch exp: %s", show(want));
							$display("mismatch got: %s", show(seen));
						end
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
// testbench top of the bmp stream decoder: clock, reset, file stimulus, stalls and verdict
module tb;
	import bsd_pkg::*;

	localparam int IdleLimit = 4000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // data_byte
	logic        s_tlast;   // is_last
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // status, rgb, dest_row, dest_col, image_width,
	                        // image_height, flip_rows, rows_done, last_pixel
	logic [1:0]  m_tuser;   // kind
	logic        m_tlast;   // done_res

	int errors;
	int pending;
	bit calm = 1'b0;
	int stall_left = 0;
	int idle_run = 0;
	int sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bmp_stream_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	bsd_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	// mostly short pauses, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 1;
		if (r < 92) return $urandom_range(2, 4);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_run = 0;
		end else begin
			idle_run++;
			if (idle_run >= IdleLimit) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = (calm || $urandom_range(0, 99) < 65) ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// header fields little-endian over random filler, then random body bytes
	task automatic send_file(input logic [15:0] sig, input logic [31:0] off,
	                         input logic [31:0] w, input logic [31:0] h,
	                         input logic [15:0] bits, input logic [31:0] comp, input int total);
		logic [7:0] hdr [HdrLen];
		for (int i = 0; i < HdrLen; i++) hdr[i] = 8'($urandom);
		{hdr[OffSig+1], hdr[OffSig]} = sig;
		{hdr[OffPix+3], hdr[OffPix+2], hdr[OffPix+1], hdr[OffPix]} = off;
		{hdr[OffWidth+3], hdr[OffWidth+2], hdr[OffWidth+1], hdr[OffWidth]} = w;
		{hdr[OffHeight+3], hdr[OffHeight+2], hdr[OffHeight+1], hdr[OffHeight]} = h;
		{hdr[OffDepth+1], hdr[OffDepth]} = bits;
		{hdr[OffComp+3], hdr[OffComp+2], hdr[OffComp+1], hdr[OffComp]} = comp;
		for (int i = 0; i < total; i++)
			push_byte((i < HdrLen) ? hdr[i] : 8'($urandom), i == total - 1);
	endtask

	// mostly valid small images; some with one broken header field, cut short or truncated
	task automatic random_file();
		logic [15:0] sig;
		logic [15:0] bits;
		logic [31:0] off;
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] comp;
		int          hm;
		int          pad;
		int          row_b;
		int          natural;
		int          total;
		int          r;
		bit          good;
		calm = ($urandom_range(0, 99) < 15);
		good = 1'b1;
		sig  = BmSig;
		bits = 16'($urandom_range(0, 1) ? Depth32 : Depth24);
		comp = '0;
		w    = $urandom_range(1, 4);
		hm   = $urandom_range(1, 3);
		h    = $urandom_range(0, 1) ? hm : -hm;
		off  = HdrLen + $urandom_range(0, 5);
		if ($urandom_range(0, 99) < 30) begin
			case ($urandom_range(0, 12))
				0:  begin sig = BmSig ^ (16'd1 << $urandom_range(0, 15)); good = 1'b0; end
				1:  begin bits = 16'($urandom); good = 1'b0; end
				2:  begin bits = 16'(Depth24) ^ (16'd1 << $urandom_range(0, 15)); good = 1'b0; end
				3:  begin comp = 32'd1 << $urandom_range(0, 31); good = 1'b0; end
				4:  begin comp = $urandom | 32'd1; good = 1'b0; end
				5:  begin w = '0; good = 1'b0; end
				6: begin
					w = $urandom_range(0, 1) ? MAX_DIM + 1 : {1'b1, 31'($urandom)};
					good = 1'b0;
				end
				7:  begin h = '0; good = 1'b0; end
				8: begin
					h = $urandom_range(0, 1) ? MAX_DIM + 1 : -(MAX_DIM + 1);
					good = 1'b0;
				end
				// magnitude of these is always beyond the largest height
				9:  begin h = 32'h8000_0000 | ($urandom & 32'h7FFF_F000); good = 1'b0; end
				10: begin off = $urandom_range(0, HdrLen - 1); good = 1'b0; end
				// accepted header whose pixel offset is never reached
				11: begin
					off = $urandom_range(0, 1) ? FILE_LIMIT + $urandom_range(0, 4096)
					                           : 32'hFFFF_FFFF;
					good = 1'b0;
				end
				default: off = $urandom_range(100, 300);
			endcase
		end
		if (good) begin
			pad     = (bits == Depth32) ? 0 : int'(w[1:0]);
			row_b   = (bits == Depth32) ? 4 * int'(w) : 3 * int'(w) + pad;
			natural = int'(off) + row_b * hm - pad + $urandom_range(0, 3);
		end else begin
			natural = HdrLen + $urandom_range(0, 6);
		end
		r = $urandom_range(0, 99);
		if (r < 72) total = natural;
		else if (r < 90) total = $urandom_range(HdrLen, natural);
		else total = $urandom_range(0, 1) ? HdrLen : $urandom_range(1, HdrLen - 1);
		send_file(sig, off, w, h, bits, comp, total);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte files at the data extremes, then files that end inside the header
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		send_file(BmSig, HdrLen, 1, 1, 16'(Depth24), 0, 2);
		send_file(BmSig, HdrLen, 1, 1, 16'(Depth24), 0, 20);

		sent = 0;
		while (sent < 950) random_file();

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
